FILE: src/u16u8_pkg.sv
// Shared types and byte encoding for the UTF-16 to UTF-8 transcoder.
`default_nettype none
package u16u8_pkg;

  typedef struct packed {
    logic [20:0] code_point;
    logic [1:0]  last_idx;
  } job_t;

  localparam int QueueDepth = 2;

  function automatic logic [7:0] encode_byte(input logic [20:0] cp,
                                             input logic [1:0]  last_idx,
                                             input logic [1:0]  idx);
    logic [7:0] b;
    logic [1:0] sel;
    b   = 8'h00;
    sel = last_idx - idx;
    if (idx == 2'd0) begin
      unique case (last_idx)
        2'd0: b = {1'b0, cp[6:0]};
        2'd1: b = {3'b110, cp[10:6]};
        2'd2: b = {4'b1110, cp[15:12]};
        2'd3: b = {5'b11110, cp[20:18]};
        default: b = 8'h00;
      endcase
    end else begin
      unique case (sel)
        2'd0: b = {2'b10, cp[5:0]};
        2'd1: b = {2'b10, cp[11:6]};
        2'd2: b = {2'b10, cp[17:12]};
        default: b = 8'h00;
      endcase
    end
    return b;
  endfunction

endpackage
`default_nettype wire

FILE: src/utf16_to_utf8_surrogate_filter_top.sv
// Top level of the UTF-16 to UTF-8 transcoder with surrogate filtering.
// Input side is a queue write port: a code unit and its string_end flag are
// taken on a clock edge with push high and full low. Output side is a queue
// read port: while empty is low, utf8_byte and run_last show the oldest byte,
// and it is consumed on an edge with pop high. run_last marks the final byte
// produced by one input unit. A high surrogate is held until the next unit;
// a following low surrogate yields four bytes, anything else drops it. Lone
// low surrogates and a high surrogate on the final unit produce nothing.
// The front end classifies a unit in the cycle it is accepted and writes a
// job into a two-entry queue; the back end takes each job into a current-job
// register and, while it holds a job and the output register is empty or
// popped, emits one byte per cycle. A unit yields one to three bytes and a
// surrogate pair four bytes over its two units; the serializer sets the pace.
// Reset (rst, synchronous) empties the queue, the output register and any
// held surrogate. When pop stays low the output register holds, the queue
// fills, and full rises to stall the sender.
`default_nettype none
module utf16_to_utf8_surrogate_filter_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [15:0] code_unit,
  input  wire logic        string_end,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       utf8_byte,
  output logic             run_last
);

  u16u8_pkg::job_t wr_job;
  u16u8_pkg::job_t rd_job;
  logic            job_push;
  logic            job_full;
  logic            job_pop;
  logic            job_empty;

  u16u8_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .code_unit  (code_unit),
    .string_end (string_end),
    .job_push   (job_push),
    .job        (wr_job),
    .job_full   (job_full)
  );

  u16u8_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (job_push),
    .wr_job (wr_job),
    .full   (job_full),
    .rd_en  (job_pop),
    .rd_job (rd_job),
    .empty  (job_empty)
  );

  u16u8_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (rd_job),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .utf8_byte (utf8_byte),
    .run_last  (run_last)
  );

endmodule
`default_nettype wire

FILE: src/u16u8_front.sv
// Front end: accepts code units, pairs surrogates and builds encode jobs.
`default_nettype none
module u16u8_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [15:0]        code_unit,
  input  wire logic               string_end,
  output logic                    job_push,
  output u16u8_pkg::job_t         job,
  input  wire logic               job_full
);

  logic       pending_valid;
  logic [9:0] pending_high_bits;
  logic       accept;
  logic       is_high;
  logic       is_low;
  logic       pair;

  assign full    = job_full;
  assign accept  = push && !job_full;
  assign is_high = code_unit[15:10] == 6'b110110;
  assign is_low  = code_unit[15:10] == 6'b110111;
  assign pair    = pending_valid && is_low;

  assign job_push = accept && (pair || (!is_high && !is_low));

  always_comb begin
    job.code_point = {5'd0, code_unit};
    job.last_idx   = 2'd2;
    if (pair) begin
      job.code_point = 21'h10000 + {1'b0, pending_high_bits, code_unit[9:0]};
      job.last_idx   = 2'd3;
    end else if (code_unit[15:7] == 9'd0) begin
      job.last_idx = 2'd0;
    end else if (code_unit[15:11] == 5'd0) begin
      job.last_idx = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid     <= 1'b0;
      pending_high_bits <= 10'd0;
    end else if (accept) begin
      pending_valid     <= is_high && !string_end;
      pending_high_bits <= code_unit[9:0];
    end
  end

endmodule
`default_nettype wire

FILE: src/u16u8_queue.sv
// Two-entry job queue between the front end and the byte serializer.
`default_nettype none
module u16u8_queue (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       wr_en,
  input  wire u16u8_pkg::job_t wr_job,
  output logic            full,
  input  wire logic       rd_en,
  output u16u8_pkg::job_t rd_job,
  output logic            empty
);

  u16u8_pkg::job_t mem [u16u8_pkg::QueueDepth];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign full   = count == 2'(u16u8_pkg::QueueDepth);
  assign empty  = count == 2'd0;
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_wr) - 2'(do_rd);
    end
  end

endmodule
`default_nettype wire

FILE: src/u16u8_back.sv
// Back end: serializes each job into UTF-8 bytes through an output register.
`default_nettype none
module u16u8_back (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire u16u8_pkg::job_t job,
  input  wire logic       job_empty,
  output logic            job_pop,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      utf8_byte,
  output logic            run_last
);

  logic            cur_valid;
  u16u8_pkg::job_t cur;
  logic [1:0]      idx;
  logic            out_valid;
  logic            load_out;
  logic            emit;
  logic            done;

  assign empty    = !out_valid;
  assign load_out = !out_valid || pop;
  assign emit     = load_out && cur_valid;
  assign done     = emit && (idx == cur.last_idx);
  assign job_pop  = !job_empty && (!cur_valid || done);

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur <= job;
    end
    if (emit) begin
      utf8_byte <= u16u8_pkg::encode_byte(cur.code_point, cur.last_idx, idx);
      run_last  <= idx == cur.last_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (job_pop) begin
        cur_valid <= 1'b1;
        idx       <= 2'd0;
      end else if (done) begin
        cur_valid <= 1'b0;
        idx       <= 2'd0;
      end else if (emit) begin
        idx <= idx + 2'd1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire
